FILE: design/slpg_pkg.sv
// Shared types and constants for the status LED pattern generator.
`default_nettype none

package slpg_pkg;

  // LED pattern modes for the heartbeat and link LEDs.
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_WAIT   = 2'd2,
    MODE_ERROR  = 2'd3
  } led_mode_t;

  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned MODE_CNT_W   = 7;
  localparam int unsigned PULSE_CNT_W  = 4;

  localparam logic [PERIOD_W-1:0]    PERIOD_RESET   = 16'd10;
  // Actions a short blink stays lit, and the blink interval in normal mode.
  localparam logic [MODE_CNT_W-1:0]  BLINK_ON_LAST  = 7'd2;
  localparam logic [MODE_CNT_W-1:0]  NORMAL_LIMIT   = 7'd100;
  // Toggle intervals in wait mode.
  localparam logic [MODE_CNT_W-1:0]  HB_WAIT_LIMIT  = 7'd5;
  localparam logic [MODE_CNT_W-1:0]  LINK_WAIT_LIMIT = 7'd30;
  // Double blink frame in error mode: lit on counts 1, 2, 10 and 11.
  localparam logic [MODE_CNT_W-1:0]  ERR_ON_A       = 7'd1;
  localparam logic [MODE_CNT_W-1:0]  ERR_ON_B       = 7'd2;
  localparam logic [MODE_CNT_W-1:0]  ERR_ON_C       = 7'd10;
  localparam logic [MODE_CNT_W-1:0]  ERR_ON_D       = 7'd11;
  localparam logic [MODE_CNT_W-1:0]  ERR_FRAME      = 7'd30;
  // Delay of a requested pulse, and how long it stays lit.
  localparam logic [PULSE_CNT_W-1:0] PULSE_DELAY    = 4'd10;
  localparam logic [PULSE_CNT_W-1:0] PULSE_ON_LAST  = 4'd2;

  // Per-request control from the pipeline to the LED units.
  typedef struct packed {
    logic step;  // a request moves into the output register this cycle
    logic fire;  // the prescaler fires an action for that request
  } slpg_ctrl_t;

endpackage

`default_nettype wire

FILE: design/slpg_mode_led.sv
// Mode-driven LED: pattern counter and LED level for heartbeat or link.
`default_nettype none

module slpg_mode_led import slpg_pkg::*; #(
  parameter logic [6:0] WAIT_LIMIT = 7'd5
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire slpg_ctrl_t            ctrl,
  input  wire logic [1:0]            mode,
  output logic                       led
);

  logic [MODE_CNT_W-1:0] count;
  logic [MODE_CNT_W-1:0] count_next;
  logic [MODE_CNT_W-1:0] err_count;
  logic                  led_next;

  assign err_count = count + 7'd1;

  // One pattern action, applied only when the prescaler fires.
  always_comb begin
    count_next = count;
    led_next   = led;
    if (ctrl.step && ctrl.fire) begin
      unique case (led_mode_t'(mode))
        MODE_OFF: begin
          led_next = 1'b0;
        end
        MODE_NORMAL: begin
          if (count > BLINK_ON_LAST) led_next = 1'b0;
          if (count < NORMAL_LIMIT) begin
            count_next = count + 7'd1;
          end else begin
            count_next = '0;
            led_next   = ~led_next;
          end
        end
        MODE_WAIT: begin
          if (count < WAIT_LIMIT) begin
            count_next = count + 7'd1;
          end else begin
            count_next = '0;
            led_next   = ~led;
          end
        end
        MODE_ERROR: begin
          led_next = (err_count == ERR_ON_A) || (err_count == ERR_ON_B) ||
                     (err_count == ERR_ON_C) || (err_count == ERR_ON_D);
          count_next = (err_count >= ERR_FRAME) ? '0 : err_count;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // Counter and LED level registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      led   <= 1'b0;
    end else begin
      count <= count_next;
      led   <= led_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/slpg_pulse_led.sv
// Request-driven LED: latches a request and gives a delayed one-action pulse.
`default_nettype none

module slpg_pulse_led import slpg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire slpg_ctrl_t ctrl,
  input  wire logic       request,
  output logic            led
);

  logic                   pending;
  logic                   pending_next;
  logic [PULSE_CNT_W-1:0] count;
  logic [PULSE_CNT_W-1:0] count_next;
  logic                   led_next;

  // Pulse action first, then the request of the same tick is latched.
  always_comb begin
    pending_next = pending;
    count_next   = count;
    led_next     = led;
    if (ctrl.step && ctrl.fire) begin
      if (!pending) begin
        led_next = 1'b0;
      end else begin
        if (count > PULSE_ON_LAST) led_next = 1'b0;
        if (count < PULSE_DELAY) begin
          count_next = count + 4'd1;
        end else begin
          count_next   = '0;
          pending_next = 1'b0;
          led_next     = ~led_next;
        end
      end
    end
    if (ctrl.step && request) pending_next = 1'b1;
  end

  // Pending flag, delay counter and LED level registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      count   <= '0;
      led     <= 1'b0;
    end else begin
      pending <= pending_next;
      count   <= count_next;
      led     <= led_next;
    end
  end

  // The delay counter only runs while a request is pending.
  assert property (@(posedge clk) disable iff (rst) !pending |-> count == '0)
    else $error("pulse counter nonzero with no request pending");

  // The counter never passes the pulse delay.
  assert property (@(posedge clk) disable iff (rst) count <= PULSE_DELAY)
    else $error("pulse counter out of range");

endmodule

`default_nettype wire

FILE: design/status_led_pattern_generator_core.sv
// Top level of the status LED pattern generator.
//
// Usage: each request on the s_ channel is one millisecond tick carrying the
// heartbeat mode, link mode and two event requests. Every tick gives exactly
// one response on the m_ channel with the four LED levels and a flag that
// tells whether the tick performed a pattern action. The prescaler fires an
// action once tick_period ticks have passed; tick_period is written through
// cfg_we/cfg_wdata, the user must write it only while the block is idle (the
// block itself does not enforce this), and 0 fires on every tick. A request
// is held in the input register and moves into the output register once the
// output side is free. Throughput: one request per cycle while m_tready is
// high, set by the single pass through the prescaler compare and LED counters
// between the two registers. Reset: all counters, pending requests and LEDs
// clear, tick_period returns to 10 and both registers empty. When m_tready is
// low the response holds, the input register still takes one more request,
// then s_tready drops.
`default_nettype none

module status_led_pattern_generator_core import slpg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // tick_period
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [1:0] hb_mode, [3:2] link_mode, [4] mems_request, [5] send_request
  input  wire logic [7:0]  s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] hb_led, [1] mems_led, [2] link_led, [3] send_led, [4] action_fired
  output logic [7:0]       m_tdata
);

  logic [PERIOD_W-1:0] tick_period;
  logic [PERIOD_W-1:0] prescale_count;
  logic [PERIOD_W:0]   prescale_inc;
  logic                in_valid;
  logic [5:0]          in_data;
  logic                out_valid;
  logic                out_fired;
  logic                advance;
  slpg_ctrl_t          ctrl;
  logic                hb_led;
  logic                mems_led;
  logic                link_led;
  logic                send_led;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      tick_period <= cfg_wdata;
    end
  end

  // Pipeline handshake: the input register moves on when the output is free.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_data <= s_tdata[5:0];
  end

  // Prescaler: an action fires once the incremented count reaches the period.
  assign prescale_inc = {1'b0, prescale_count} + 17'd1;
  assign ctrl.step    = advance;
  assign ctrl.fire    = prescale_inc >= {1'b0, tick_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
    end else if (advance) begin
      prescale_count <= ctrl.fire ? '0 : prescale_inc[PERIOD_W-1:0];
    end
  end

  // LED units; their level registers form the output register payload.
  slpg_mode_led #(.WAIT_LIMIT(HB_WAIT_LIMIT)) u_hb (
    .clk(clk), .rst(rst), .ctrl(ctrl), .mode(in_data[1:0]), .led(hb_led)
  );

  slpg_pulse_led u_mems (
    .clk(clk), .rst(rst), .ctrl(ctrl), .request(in_data[4]), .led(mems_led)
  );

  slpg_mode_led #(.WAIT_LIMIT(LINK_WAIT_LIMIT)) u_link (
    .clk(clk), .rst(rst), .ctrl(ctrl), .mode(in_data[3:2]), .led(link_led)
  );

  slpg_pulse_led u_send (
    .clk(clk), .rst(rst), .ctrl(ctrl), .request(in_data[5]), .led(send_led)
  );

  // Output register control and action flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_fired <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      out_fired <= ctrl.fire;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_fired, send_led, link_led, mems_led, hb_led};

  // A fired action leaves the prescaler at zero until the next request moves.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && out_fired |-> prescale_count == '0)
    else $error("prescaler not cleared after an action");

  // LED levels only change when a request moves into the output register.
  assert property (@(posedge clk) disable iff (rst)
                   !advance |=> $stable(m_tdata[3:0]))
    else $error("LED levels changed without a request");

  // A held request never waits on an empty output register.
  assert property (@(posedge clk) disable iff (rst)
                   in_valid && !out_valid |-> advance)
    else $error("input register stalled with output empty");

  // Every moved request produces a response.
  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("request moved without a response");

endmodule

`default_nettype wire

FILE: dv/status_led_pattern_generator_core_tb.sv
// Self-checking testbench for the status LED pattern generator core.
`timescale 1ns / 1ps

module status_led_pattern_generator_core_tb;
  import slpg_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NUM_PHASES     = 8;
  localparam int LONG_PHASE     = 3;
  localparam int LONG_TICKS     = 100;
  localparam int PHASE_TICKS    = 130;
  localparam int DIR_ROWS       = 20;

  // One tick request, packed as on s_tdata.
  typedef struct packed {
    logic      send_request;
    logic      mems_request;
    led_mode_t link_mode;
    led_mode_t hb_mode;
  } tick_req_t;

  // One response, packed as on m_tdata.
  typedef struct packed {
    logic action_fired;
    logic send_led;
    logic link_led;
    logic mems_led;
    logic hb_led;
  } led_result_t;

  // A directed row, with an optional tick_period write ahead of it.
  typedef struct packed {
    logic        wr_period;
    logic [15:0] period;
    led_mode_t   hb_mode;
    led_mode_t   link_mode;
    logic        mems_request;
    logic        send_request;
    logic        typed;
    led_result_t leds;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  // Shared state of the bench.
  led_result_t expected_leds_q[$];
  int          mismatch_count = 0;
  int          response_count = 0;
  int          tick_count = 0;
  int          action_count = 0;
  int          idle_cycles = 0;
  bit          idle_on = 1'b1;

  // Predictor copy of the block state.
  logic [15:0] period_q;
  logic [15:0] prescale;
  logic [6:0]  hb_cnt;
  logic [6:0]  link_cnt;
  logic [3:0]  mems_cnt;
  logic [3:0]  send_cnt;
  logic        mems_pend;
  logic        send_pend;
  led_result_t led_state;

  // Heartbeat in all modes, the pulse delay of 11 actions, and the request
  // that arrives on the action that finishes a pulse.
  directed_row_t dir_table [0:DIR_ROWS-1] = '{
    '{1'b0, 16'd0, MODE_OFF,    MODE_OFF,    1'b0, 1'b0, 1'b1, 5'b00000},
    '{1'b0, 16'd0, MODE_ERROR,  MODE_ERROR,  1'b1, 1'b1, 1'b1, 5'b00000},
    '{1'b1, 16'd0, MODE_ERROR,  MODE_ERROR,  1'b0, 1'b0, 1'b1, 5'b10101},
    '{1'b0, 16'd0, MODE_ERROR,  MODE_ERROR,  1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_NORMAL, MODE_WAIT,   1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_NORMAL, MODE_WAIT,   1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_WAIT,   MODE_NORMAL, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_WAIT,   MODE_NORMAL, 1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_OFF,    MODE_OFF,    1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_WAIT,   MODE_ERROR,  1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_NORMAL, MODE_OFF,    1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_ERROR,  MODE_WAIT,   1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_OFF,    MODE_NORMAL, 1'b1, 1'b1, 1'b0, 5'b00000},
    '{1'b1, 16'd1, MODE_ERROR,  MODE_ERROR,  1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_NORMAL, MODE_NORMAL, 1'b0, 1'b1, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_WAIT,   MODE_WAIT,   1'b1, 1'b0, 1'b0, 5'b00000},
    '{1'b1, 16'd2, MODE_OFF,    MODE_OFF,    1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_ERROR,  MODE_NORMAL, 1'b1, 1'b1, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_WAIT,   MODE_OFF,    1'b0, 1'b0, 1'b0, 5'b00000},
    '{1'b0, 16'd0, MODE_NORMAL, MODE_ERROR,  1'b1, 1'b1, 1'b0, 5'b00000}
  };

  status_led_pattern_generator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Clock generation.
  initial begin
    forever begin
      #2 clk = ~clk;
    end
  end

  // One action of a mode-driven LED; the counter is shared by all modes.
  function automatic void step_mode_led(input led_mode_t mode, inout logic [6:0] cnt,
                                        inout logic led, input logic [6:0] wait_limit);
    case (mode)
      MODE_OFF: begin
        led = 1'b0;
      end
      MODE_NORMAL: begin
        if (cnt > 7'd2) led = 1'b0;
        if (cnt < 7'd100) begin
          cnt = cnt + 7'd1;
        end else begin
          cnt = '0;
          led = ~led;
        end
      end
      MODE_WAIT: begin
        if (cnt < wait_limit) begin
          cnt = cnt + 7'd1;
        end else begin
          cnt = '0;
          led = ~led;
        end
      end
      default: begin
        cnt = cnt + 7'd1;
        led = (cnt == 7'd1 || cnt == 7'd2 || cnt == 7'd10 || cnt == 7'd11);
        if (cnt >= 7'd30) cnt = '0;
      end
    endcase
  endfunction

  // One action of a request-driven pulse LED.
  function automatic void step_pulse_led(inout logic pend, inout logic [3:0] cnt,
                                         inout logic led);
    if (!pend) begin
      led = 1'b0;
    end else begin
      if (cnt > 4'd2) led = 1'b0;
      if (cnt < 4'd10) begin
        cnt = cnt + 4'd1;
      end else begin
        cnt  = '0;
        pend = 1'b0;
        led  = ~led;
      end
    end
  endfunction

  // Advance the predicted state by one tick and return the LED response.
  function automatic led_result_t predict_tick(input tick_req_t req);
    logic [16:0] nxt;
    led_result_t res;
    nxt = {1'b0, prescale} + 17'd1;
    led_state.action_fired = 1'b0;
    if (nxt >= {1'b0, period_q}) begin
      prescale = '0;
      led_state.action_fired = 1'b1;
      action_count++;
      step_mode_led(req.hb_mode, hb_cnt, led_state.hb_led, 7'd5);
      step_pulse_led(mems_pend, mems_cnt, led_state.mems_led);
      step_mode_led(req.link_mode, link_cnt, led_state.link_led, 7'd30);
      step_pulse_led(send_pend, send_cnt, led_state.send_led);
    end else begin
      prescale = nxt[15:0];
    end
    // Requests latch after the action of the same tick.
    if (req.mems_request) mems_pend = 1'b1;
    if (req.send_request) send_pend = 1'b1;
    res = led_state;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [4:0] got,
                                 input logic [4:0] want);
    $display("MISMATCH response %0d %s: got %b expected %b", response_count, what, got,
             want);
    mismatch_count++;
  endtask

  // Send one tick request after a random gap and queue its expected response.
  task automatic send_tick(input tick_req_t req, input bit typed,
                           input led_result_t typed_leds);
    int gap;
    led_result_t predicted;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, req};
    do @(posedge clk); while (!s_tready);
    predicted = predict_tick(req);
    expected_leds_q.push_back(typed ? typed_leds : predicted);
    tick_count++;
  endtask

  // Let every outstanding response drain before touching the register.
  task automatic wait_until_idle();
    s_tvalid <= 1'b0;
    while (expected_leds_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tick_period(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    period_q = value;
  endtask

  // Response side: random stalls, then compare each response field by field.
  initial begin
    led_result_t got;
    led_result_t want;
    string       field_name [5];
    int          stall;
    field_name = '{"hb_led", "mems_led", "link_led", "send_led", "action_fired"};
    wait (!rst);
    forever begin
      stall = idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata[4:0];
      if (expected_leds_q.size() == 0) begin
        report_mismatch("with no request outstanding", got, '0);
      end else begin
        want = expected_leds_q.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (got[i] !== want[i]) report_mismatch(field_name[i], got, want);
        end
      end
      response_count++;
    end
  end

  // Watchdog on cycles in which no request or response moves.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", idle_cycles);
        $display("status_led_pattern_generator_core regression: fail");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    tick_req_t   req;
    led_mode_t   hb_base;
    led_mode_t   link_base;
    logic [15:0] phase_period [NUM_PHASES];
    int          n_ticks;

    // Predictor reset state.
    period_q  = 16'd10;
    prescale  = '0;
    hb_cnt    = '0;
    link_cnt  = '0;
    mems_cnt  = '0;
    send_cnt  = '0;
    mems_pend = 1'b0;
    send_pend = 1'b0;
    led_state = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].wr_period) begin
        wait_until_idle();
        write_tick_period(dir_table[r].period);
      end
      req.hb_mode      = dir_table[r].hb_mode;
      req.link_mode    = dir_table[r].link_mode;
      req.mems_request = dir_table[r].mems_request;
      req.send_request = dir_table[r].send_request;
      send_tick(req, dir_table[r].typed, dir_table[r].leds);
    end

    // Random phases; the long-period one runs back to back at the top period.
    phase_period = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2,
                     16'($urandom_range(4, 12)), 16'd1, 16'($urandom_range(13, 60))};
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_until_idle();
      write_tick_period(phase_period[p]);
      idle_on   = (p == LONG_PHASE) ? 1'b0 : ($urandom_range(0, 3) != 0);
      n_ticks   = (p == LONG_PHASE) ? LONG_TICKS : PHASE_TICKS;
      hb_base   = (p == 0) ? MODE_NORMAL : led_mode_t'($urandom_range(0, 3));
      link_base = (p == 0) ? MODE_NORMAL : led_mode_t'($urandom_range(0, 3));
      for (int i = 0; i < n_ticks; i++) begin
        // Modes mostly hold so the long patterns complete; a few ticks deviate.
        if ($urandom_range(0, 199) == 0) hb_base = led_mode_t'($urandom_range(0, 3));
        if ($urandom_range(0, 199) == 0) link_base = led_mode_t'($urandom_range(0, 3));
        req.hb_mode   = ($urandom_range(0, 31) == 0) ? led_mode_t'($urandom_range(0, 3))
                                                     : hb_base;
        req.link_mode = ($urandom_range(0, 31) == 0) ? led_mode_t'($urandom_range(0, 3))
                                                     : link_base;
        req.mems_request = ($urandom_range(0, 15) == 0);
        req.send_request = ($urandom_range(0, 15) == 0);
        send_tick(req, 1'b0, '0);
      end
    end

    // Drain and finish.
    s_tvalid <= 1'b0;
    while (expected_leds_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d ticks with %0d pattern actions over %0d tick_period settings,",
             tick_count, action_count, NUM_PHASES + 3);
    $display("including periods 0, 1, 2 and 65535; %0d responses checked.", response_count);
    if (mismatch_count == 0) begin
      $display("status_led_pattern_generator_core regression: pass");
    end else begin
      $display("status_led_pattern_generator_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: status_led_pattern_generator_core.f
design/slpg_pkg.sv
design/slpg_mode_led.sv
design/slpg_pulse_led.sv
design/status_led_pattern_generator_core.sv
dv/status_led_pattern_generator_core_tb.sv
